// ----- rtl/core/btas_pkg.sv -----
package btas_pkg;

    localparam int REGISTER_COUNT = 16;
    localparam int LIST_W         = 16;
    localparam int IDX_W          = 4;
    localparam int CNT_W          = 5;
    localparam int WORD_W         = 32;
    localparam int SCAN_N         = (REGISTER_COUNT < LIST_W) ? REGISTER_COUNT : LIST_W;

    localparam logic [LIST_W-1:0] SCAN_MASK = LIST_W'((64'd1 << SCAN_N) - 64'd1);
    localparam logic [IDX_W-1:0]  PC_INDEX  = IDX_W'(LIST_W - 1);
    localparam logic [WORD_W-1:0] WORD_STEP = WORD_W'(4);

    typedef struct packed {
        logic                pre_index;
        logic                up;
        logic                s_bit;
        logic                write_back;
        logic                is_load;
        logic [IDX_W-1:0]    base_register;
        logic [LIST_W-1:0]   register_list;
        logic [WORD_W-1:0]   base_value;
    } t_in_item;

    typedef struct packed {
        logic                transfer_valid;
        logic [IDX_W-1:0]    register_index;
        logic [WORD_W-1:0]   word_address;
        logic                load_access;
        logic                user_bank;
        logic                restore_status;
        logic                writeback_enable;
        logic [WORD_W-1:0]   writeback_value;
        logic                last;
    } t_out_item;

    // request to the shared adder
    typedef struct packed {
        logic                sub;
        logic [WORD_W-1:0]   a;
        logic [WORD_W-1:0]   b;
    } t_alu_req;

    // status of the remaining register list
    typedef struct packed {
        logic                found;
        logic                last;
        logic [IDX_W-1:0]    idx;
        logic [CNT_W-1:0]    count;
    } t_scan;

endpackage

// ----- rtl/core/block_transfer_address_sequencer.sv -----
// channel   dir  handshake                  payload
// in        in   i_in_valid / o_in_ready    i_in_item  (t_in_item)
// out       out  o_out_valid / i_out_ready  o_out_item (t_out_item)
//
// an instruction passes through accept, writeback sum and start address, then emits
// one transfer per cycle while the output register is free (one result for an empty list)
// the shared 32-bit adder serves the writeback sum, the start address and each next address
// reset is synchronous, active low, and clears the sequencer and output valid
// a stalled output holds its transfer; the sequencer waits on a full output register
module block_transfer_address_sequencer
    import btas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WB,
        S_ADDR,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;

    // latched instruction
    logic               r_pre, n_pre;
    logic               r_up, n_up;
    logic               r_load, n_load;
    logic               r_user, n_user;
    logic               r_restore, n_restore;
    logic               r_wben, n_wben;
    logic [LIST_W-1:0]  r_list, n_list;
    logic [WORD_W-1:0]  r_base, n_base;
    logic [WORD_W-1:0]  r_wbval, n_wbval;
    logic [WORD_W-1:0]  r_addr, n_addr;

    // output register
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    t_alu_req           w_req;
    logic [WORD_W-1:0]  w_sum;
    t_scan              w_scan;
    logic [LIST_W-1:0]  w_in_list;
    logic               w_slot_free;
    logic               w_in_restore;

    btas_alu u_alu (
        .i_req (w_req),
        .o_sum (w_sum)
    );

    btas_scan u_scan (
        .i_list (r_list),
        .o_scan (w_scan)
    );

    assign w_in_list    = i_in_item.register_list & SCAN_MASK;
    assign w_in_restore = i_in_item.s_bit && i_in_item.is_load && w_in_list[PC_INDEX];
    assign w_slot_free  = !r_out_valid || i_out_ready;

    // shared adder operand selection
    always_comb begin
        w_req.sub = 1'b0;
        w_req.a   = r_addr;
        w_req.b   = WORD_STEP;
        unique case (r_state)
            S_WB: begin
                // base plus or minus four per listed register
                w_req.sub = !r_up;
                w_req.a   = r_base;
                w_req.b   = WORD_W'({w_scan.count, 2'b00});
            end
            S_ADDR: begin
                if (r_up) begin
                    w_req.a = r_base;
                    w_req.b = r_pre ? WORD_STEP : '0;
                end else begin
                    // descending modes start at the lowest word of the block
                    w_req.a = r_wbval;
                    w_req.b = r_pre ? '0 : WORD_STEP;
                end
            end
            S_IDLE, S_EMIT: begin
                // next word address
                w_req.a = r_addr;
                w_req.b = WORD_STEP;
            end
            default: begin
                w_req.a = r_addr;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_pre       = r_pre;
        n_up        = r_up;
        n_load      = r_load;
        n_user      = r_user;
        n_restore   = r_restore;
        n_wben      = r_wben;
        n_list      = r_list;
        n_base      = r_base;
        n_wbval     = r_wbval;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pre     = i_in_item.pre_index;
                    n_up      = i_in_item.up;
                    n_load    = i_in_item.is_load;
                    n_restore = w_in_restore;
                    n_user    = i_in_item.s_bit && !w_in_restore;
                    // a load that reloads the base wins over writeback
                    n_wben    = i_in_item.write_back &&
                                !(i_in_item.is_load && w_in_list[i_in_item.base_register]);
                    n_list    = w_in_list;
                    n_base    = i_in_item.base_value;
                    n_state   = S_WB;
                end
            end
            S_WB: begin
                n_wbval = w_sum;
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_addr  = w_sum;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    if (!w_scan.found) begin
                        // empty list: one result, no transfer
                        n_out.transfer_valid   = 1'b0;
                        n_out.register_index   = '0;
                        n_out.word_address     = '0;
                        n_out.load_access      = r_load;
                        n_out.user_bank        = 1'b0;
                        n_out.restore_status   = 1'b0;
                        n_out.writeback_enable = r_wben;
                        n_out.writeback_value  = r_base;
                        n_out.last             = 1'b1;
                        n_state                = S_IDLE;
                    end else begin
                        n_out.transfer_valid   = 1'b1;
                        n_out.register_index   = w_scan.idx;
                        n_out.word_address     = r_addr;
                        n_out.load_access      = r_load;
                        n_out.user_bank        = r_user;
                        n_out.restore_status   = w_scan.last && r_restore;
                        n_out.writeback_enable = w_scan.last && r_wben;
                        n_out.writeback_value  = w_scan.last ? r_wbval : '0;
                        n_out.last             = w_scan.last;
                        n_list[w_scan.idx]     = 1'b0;
                        n_addr                 = w_sum;
                        if (w_scan.last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_pre     <= n_pre;
        r_up      <= n_up;
        r_load    <= n_load;
        r_user    <= n_user;
        r_restore <= n_restore;
        r_wben    <= n_wben;
        r_list    <= n_list;
        r_base    <= n_base;
        r_wbval   <= n_wbval;
        r_addr    <= n_addr;
        r_out     <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // a result without a transfer only comes from an empty list, and is the last
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.transfer_valid) |-> o_out_item.last)
        else $error("result without transfer is not last");

    // per-instruction flags only appear on the final result
    a_flags_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.last) |->
            (o_out_item.writeback_value == '0 && !o_out_item.restore_status &&
             !o_out_item.writeback_enable))
        else $error("writeback or restore flagged before last result");

    a_user_or_restore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.user_bank && o_out_item.restore_status))
        else $error("user bank and status restore both set");

    // the sequencer is busy right after taking an instruction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accepting an instruction");
`endif

endmodule

// ----- rtl/core/btas_alu.sv -----
module btas_alu
    import btas_pkg::*;
(
    input  t_alu_req            i_req,
    output logic [WORD_W-1:0]   o_sum
);

    // single add/subtract, wraps modulo 2^32
    assign o_sum = i_req.sub ? (i_req.a - i_req.b) : (i_req.a + i_req.b);

endmodule

// ----- rtl/core/btas_scan.sv -----
module btas_scan
    import btas_pkg::*;
(
    input  logic [LIST_W-1:0]   i_list,
    output t_scan               o_scan
);

    logic [IDX_W-1:0] w_idx;
    logic [CNT_W-1:0] w_count;
    logic [LIST_W-1:0] w_rest;

    // lowest set bit wins
    always_comb begin
        w_idx = '0;
        for (int i = LIST_W - 1; i >= 0; i--) begin
            if (i_list[i]) begin
                w_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        w_count = '0;
        for (int i = 0; i < LIST_W; i++) begin
            w_count = w_count + CNT_W'(i_list[i]);
        end
    end

    assign w_rest = i_list & (i_list - LIST_W'(1));

    assign o_scan.found = |i_list;
    assign o_scan.last  = (|i_list) && (w_rest == '0);
    assign o_scan.idx   = w_idx;
    assign o_scan.count = w_count;

endmodule
